[rtl/core/dlc_pkg.sv]
// Shared types and constants of the display-list coprocessor.
// No dependencies; used by every module in rtl/core.
package dlc_pkg;

  // Item operation codes
  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_RESUME  = 2'd2;

  // Control state codes
  localparam logic [2:0] ST_HALTED      = 3'd0;
  localparam logic [2:0] ST_FETCH1      = 3'd1;
  localparam logic [2:0] ST_MOVE2       = 3'd2;
  localparam logic [2:0] ST_WS2         = 3'd3;
  localparam logic [2:0] ST_WAIT_RASTER = 3'd4;
  localparam logic [2:0] ST_WAIT_BLIT   = 3'd5;

  // Instruction decode constants
  localparam logic [15:0] STOP_FIRST     = 16'hFFFF;
  localparam logic [15:0] STOP_SECOND    = 16'hFFFE;
  localparam logic [15:0] POS_MASK       = 16'hFFFE;
  localparam logic [15:0] MASK_KEEP      = 16'h7FFE;
  localparam logic [15:0] MASK_FORCE     = 16'h8001;
  localparam logic [8:0]  REG_MASK       = 9'h1FE;
  localparam logic [8:0]  REG_LOW_SAFE   = 9'h080;
  localparam logic [8:0]  REG_LOW_DANGER = 9'h040;
  localparam logic [7:0]  HPOS_WRAP      = 8'hE0;
  localparam logic [7:0]  HPOS_MASK      = 8'hFE;

  // One input item
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] fetch_data;
    logic [7:0]  beam_vpos;
    logic [7:0]  beam_hpos;
    logic        blitter_busy;
    logic [20:0] restart_address;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [2:0]  copper_state;
    logic [20:0] fetch_address;
    logic        write_valid;
    logic [8:0]  write_register;
    logic [15:0] write_data;
    logic        illegal_halt;
  } result_t;

endpackage

[rtl/core/display_list_coprocessor.sv]
// Top level of the display-list coprocessor: input and result registers.
// Depends on dlc_pkg and dlc_exec (which uses dlc_beam_cmp).
//
// Usage: each slave-side item carries one operation in tuser (step with
// the instruction word fetched at the last reported fetch_address, restart
// at a new address, or resume from a wait) plus beam position and blitter
// status in tdata. Every item yields exactly one master-side item with the
// new control state, the next fetch address and any register move.
// Each item passes through the input register and then the result
// register. Throughput is one item per cycle while the receiver keeps
// taking results. A stalled receiver holds the result register, the
// input register then fills and tready drops until the result is
// taken. Reset halts the block with program counter zero and
// danger_enable clear; a restart item is needed to begin. The single
// configuration bit is written through cfg_wr_en_i; the user must
// write it only while no item is in flight, as the block itself does
// not enforce this.
module display_list_coprocessor #(
  parameter int ADDRESS_BITS = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: danger_enable
  input  logic        cfg_wr_en_i,
  input  logic        cfg_wr_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // fetch_data[15:0], beam_vpos[23:16], beam_hpos[31:24], blitter_busy[32],
  // restart_address[53:33], zero[55:54]
  input  logic [55:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // copper_state[2:0], fetch_address[23:3], write_valid[24],
  // write_register[33:25], write_data[49:34], illegal_halt[50], zero[55:51]
  output logic [55:0] m_axis_tdata_o
);

  dlc_pkg::in_item_t in_q, in_d;
  logic              in_valid_q;
  dlc_pkg::result_t  out_q;
  dlc_pkg::result_t  result;
  logic              out_valid_q;
  logic              advance;
  logic              in_take;

  // Move an item on when the result register is free or being drained
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Unpack the incoming item
  always_comb begin
    in_d.operation       = s_axis_tuser_i;
    in_d.fetch_data      = s_axis_tdata_i[15:0];
    in_d.beam_vpos       = s_axis_tdata_i[23:16];
    in_d.beam_hpos       = s_axis_tdata_i[31:24];
    in_d.blitter_busy    = s_axis_tdata_i[32];
    in_d.restart_address = s_axis_tdata_i[53:33];
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_d;
    end
  end

  dlc_exec #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .step_en_i     (advance),
    .item_i        (in_q),
    .result_o      (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  // Pack the result item
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.illegal_halt, out_q.write_data,
                            out_q.write_register, out_q.write_valid,
                            out_q.fetch_address, out_q.copper_state};

endmodule

[rtl/core/dlc_beam_cmp.sv]
// Masked beam position compare for WAIT and SKIP instructions.
// Depends on dlc_pkg for the horizontal wrap constants.
module dlc_beam_cmp (
  input  logic [15:0] wait_pos_i,
  input  logic [15:0] wait_mask_i,
  input  logic [7:0]  beam_vpos_i,
  input  logic [7:0]  beam_hpos_i,
  output logic        pass_o
);

  logic [7:0] v_mask;
  logic [7:0] v_wait;
  logic [7:0] v_beam;
  logic [7:0] h_mask;
  logic [7:0] h_wait;
  logic [7:0] h_beam;
  logic [7:0] h_adv;

  // Split both words into masked vertical and horizontal parts
  assign v_mask = wait_mask_i[15:8];
  assign v_wait = wait_pos_i[15:8] & v_mask;
  assign v_beam = beam_vpos_i & v_mask;
  assign h_mask = wait_mask_i[7:0] & dlc_pkg::HPOS_MASK;
  assign h_wait = wait_pos_i[7:0] & dlc_pkg::HPOS_MASK;
  assign h_beam = beam_hpos_i & dlc_pkg::HPOS_MASK;

  // Advance the horizontal beam by one slot, wrapping at end of line
  assign h_adv = (h_beam < dlc_pkg::HPOS_WRAP) ? ((h_beam + 8'd2) & dlc_pkg::HPOS_MASK)
                                              : ((h_beam - dlc_pkg::HPOS_WRAP)
                                                 & dlc_pkg::HPOS_MASK);

  // Vertical decides unless equal, then horizontal at-or-past
  always_comb begin
    if (v_beam > v_wait) begin
      pass_o = 1'b1;
    end else if (v_beam < v_wait) begin
      pass_o = 1'b0;
    end else begin
      pass_o = ((h_adv & h_mask) >= (h_wait & h_mask));
    end
  end

endmodule

[rtl/core/dlc_exec.sv]
// Instruction decode and architectural state of the coprocessor.
// Depends on dlc_pkg and dlc_beam_cmp.
module dlc_exec #(
  parameter int ADDRESS_BITS = 21
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic               cfg_wr_data_i,
  input  logic               step_en_i,
  input  dlc_pkg::in_item_t  item_i,
  output dlc_pkg::result_t   result_o
);

  localparam int AW = ADDRESS_BITS;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] pc_q, pc_d;
  logic [15:0]   first_q, first_d;
  logic          danger_q;

  logic [AW-1:0]    pc_inc2;
  logic [AW+20:0]   raddr_ext;
  logic [AW-1:0]    raddr_pc;
  logic [8:0]       move_reg;
  logic [8:0]       move_low;
  logic [15:0]      wait_pos;
  logic [15:0]      wait_mask;
  logic             beam_pass;
  logic             is_stop;

  // Address arithmetic wraps at the program counter width
  assign pc_inc2   = pc_q + AW'(2);
  assign raddr_ext = {{AW{1'b0}}, item_i.restart_address};
  assign raddr_pc  = raddr_ext[AW-1:0] & ~AW'(1);

  // Decode fields of the instruction pair
  assign move_reg  = first_q[8:0] & dlc_pkg::REG_MASK;
  assign move_low  = danger_q ? dlc_pkg::REG_LOW_DANGER : dlc_pkg::REG_LOW_SAFE;
  assign wait_pos  = first_q & dlc_pkg::POS_MASK;
  assign wait_mask = (item_i.fetch_data & dlc_pkg::MASK_KEEP) | dlc_pkg::MASK_FORCE;
  assign is_stop   = (first_q == dlc_pkg::STOP_FIRST) &&
                     ((item_i.fetch_data & dlc_pkg::STOP_SECOND) == dlc_pkg::STOP_SECOND);

  dlc_beam_cmp u_beam_cmp (
    .wait_pos_i  (wait_pos),
    .wait_mask_i (wait_mask),
    .beam_vpos_i (item_i.beam_vpos),
    .beam_hpos_i (item_i.beam_hpos),
    .pass_o      (beam_pass)
  );

  // Next state and result for the item in the input register
  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    first_d  = first_q;
    result_o = '0;
    unique case (item_i.operation)
      dlc_pkg::OP_RESTART: begin
        first_d = '0;
        pc_d    = raddr_pc;
        state_d = dlc_pkg::ST_FETCH1;
      end
      dlc_pkg::OP_RESUME: begin
        if (state_q == dlc_pkg::ST_WAIT_RASTER || state_q == dlc_pkg::ST_WAIT_BLIT) begin
          state_d = dlc_pkg::ST_FETCH1;
        end
      end
      dlc_pkg::OP_STEP: begin
        unique case (state_q)
          dlc_pkg::ST_FETCH1: begin
            first_d = item_i.fetch_data;
            pc_d    = pc_inc2;
            state_d = item_i.fetch_data[0] ? dlc_pkg::ST_WS2 : dlc_pkg::ST_MOVE2;
          end
          dlc_pkg::ST_MOVE2: begin
            pc_d = pc_inc2;
            if (move_reg < move_low) begin
              result_o.illegal_halt = 1'b1;
              state_d = dlc_pkg::ST_HALTED;
            end else begin
              result_o.write_valid    = 1'b1;
              result_o.write_register = move_reg;
              result_o.write_data     = item_i.fetch_data;
              state_d = dlc_pkg::ST_FETCH1;
            end
          end
          dlc_pkg::ST_WS2: begin
            pc_d = pc_inc2;
            if (is_stop) begin
              state_d = dlc_pkg::ST_HALTED;
            end else if (item_i.fetch_data[0]) begin
              // Skip: jump past the next instruction when the beam is there
              if (beam_pass) begin
                pc_d = pc_q + AW'(6);
              end
              state_d = dlc_pkg::ST_FETCH1;
            end else if (!item_i.fetch_data[15] && item_i.blitter_busy) begin
              state_d = dlc_pkg::ST_WAIT_BLIT;
            end else if (beam_pass) begin
              state_d = dlc_pkg::ST_FETCH1;
            end else begin
              state_d = dlc_pkg::ST_WAIT_RASTER;
            end
          end
          default: begin
            state_d = state_q;
          end
        endcase
      end
      default: begin
        state_d = state_q;
      end
    endcase
    result_o.copper_state  = state_d;
    result_o.fetch_address = 21'(pc_d);
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlc_pkg::ST_HALTED;
      pc_q    <= '0;
      first_q <= '0;
    end else if (step_en_i) begin
      state_q <= state_d;
      pc_q    <= pc_d;
      first_q <= first_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      danger_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      danger_q <= cfg_wr_data_i;
    end
  end

endmodule
